// ===== design/tmsw_pkg.sv =====
// Shared types and constants for the trimmed-mean sample window.
package tmsw_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 10'h3FF;
	localparam logic [SAMPLE_W-1:0] MAX_VALID_RESET = 10'd255;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TRIM,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== design/tmsw_window_mem.sv =====
// Window sample store: one write port, one registered read port, cleared by valid bits.
module tmsw_window_mem
	import tmsw_pkg::*;
#(
	parameter int unsigned DEPTH = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [SAMPLE_W-1:0]        wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [SAMPLE_W-1:0]        rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/tmsw_divider.sv =====
// Division by a fixed divisor through a registered reciprocal multiply.
module tmsw_divider #(
	parameter int unsigned NUM_W   = 14,
	parameter int unsigned DIVISOR = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int unsigned     SH         = NUM_W + $clog2(DIVISOR);
	localparam longint unsigned RECIP_FULL = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
	localparam logic [NUM_W:0]  RECIP      = (NUM_W + 1)'(RECIP_FULL);

	logic [2*NUM_W:0] prod;
	logic [NUM_W-1:0] quot_q;
	logic             done_q;

	assign prod = (2*NUM_W + 1)'(numer) * (2*NUM_W + 1)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= NUM_W'(prod >> SH);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== design/trimmed_mean_sample_window_core.sv =====
// Top level: sample admission, window scan and trimmed-mean sequencing.
// From request to result: the scan reads each window entry in turn,
// then trim, reciprocal divide and output load follow.
// Requests are taken only while idle, so a new one waits until the last result is loaded;
// a stalled result lets one more request in, then holds s_tready low.
// Reset (arst_n low) clears the window to zero, the write slot to zero and max_valid to 255.
module trimmed_mean_sample_window_core
	import tmsw_pkg::*;
#(
	parameter int unsigned WINDOW_SIZE = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
	input  logic        s_tuser,   // [0] read_error
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] average, [15:10] zero
	output logic        m_tuser,   // [0] accepted
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);

	localparam int unsigned AW    = $clog2(WINDOW_SIZE);
	localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
	localparam int unsigned SUM_W = $clog2(WINDOW_SIZE * 1023 + 1);

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] max_valid_q;
	logic [AW-1:0]       wslot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic                ok_q;
	logic                m_valid_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic                ok_m_q;

	logic                accept;
	logic                ok;
	logic                mem_we;
	logic                mem_re;
	logic [SAMPLE_W-1:0] rd_data;
	logic                div_start;
	logic                div_done;
	logic [SUM_W-1:0]    trimmed;
	logic [SUM_W-1:0]    quot;
	logic                out_load;

	assign accept = s_tvalid && s_tready;
	assign ok     = !s_tuser && (s_tdata[SAMPLE_W-1:0] <= max_valid_q);
	assign mem_we = accept && ok;
	assign mem_re = (state_q == ST_SCAN) && (cnt_q < CNT_W'(WINDOW_SIZE));

	assign trimmed = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);

	tmsw_window_mem #(
		.DEPTH (WINDOW_SIZE)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (wslot_q),
		.wdata  (s_tdata[SAMPLE_W-1:0]),
		.re     (mem_re),
		.raddr  (cnt_q[AW-1:0]),
		.rdata  (rd_data)
	);

	tmsw_divider #(
		.NUM_W   (SUM_W),
		.DIVISOR (WINDOW_SIZE - 2)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (trimmed),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(WINDOW_SIZE)) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_valid_q <= MAX_VALID_RESET;
			wslot_q     <= '0;
			cnt_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_valid_q <= cfg_wdata;
			end
			if (mem_we) begin
				wslot_q <= (wslot_q == AW'(WINDOW_SIZE - 1)) ? '0 : wslot_q + 1'b1;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q  <= ok;
			sum_q <= '0;
			lo_q  <= SAMPLE_TOP;
			hi_q  <= '0;
		end else if (state_q == ST_SCAN && cnt_q != '0) begin
			sum_q <= sum_q + SUM_W'(rd_data);
			if (rd_data < lo_q) begin
				lo_q <= rd_data;
			end
			if (rd_data > hi_q) begin
				hi_q <= rd_data;
			end
		end
		if (out_load) begin
			avg_q  <= quot[SAMPLE_W-1:0];
			ok_m_q <= ok_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, avg_q};
	assign m_tuser  = ok_m_q;

endmodule

// ===== design/tmsw_checker.sv =====
// Port-level checker for the trimmed-mean sample window, bound to the top level.
module tmsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
	else $error("result request dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
	else $error("result payload changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("second request taken while one is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
	else $error("result appeared one cycle after request");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:10] == 6'b0)
	else $error("average exceeds sample range");

endmodule

bind trimmed_mean_sample_window_core tmsw_checker u_tmsw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
